// ===== sv/dtti_pkg.sv =====
// Shared types and constants for the decimal text to integer converter.
package dtti_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MALFORMED = 2'd1;
  localparam status_t ST_OVER64    = 2'd2;
  localparam status_t ST_RANGE     = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Largest magnitude that can take one more digit d without passing 2^64-1:
  // (2^64-1-d)/10, which only depends on whether d is above five.
  localparam logic [63:0] OVF_LIM_LOW_DIGIT  = 64'd1844674407370955161;
  localparam logic [63:0] OVF_LIM_HIGH_DIGIT = 64'd1844674407370955160;

  localparam logic [1:0] WCODE_8BYTE = 2'd3;

  // One accepted input beat.
  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       last_char;
    logic [1:0] width_code;
    logic       is_signed_field;
  } item_t;

  // Gathered state of one finished text, handed to the result stage.
  typedef struct packed {
    logic [63:0] magnitude;
    logic        is_negative;
    logic        digit_seen;
    status_t     error_code;
    logic [1:0]  width_code;
    logic        is_signed_field;
  } snap_t;

endpackage

// ===== sv/dtti_accum.sv =====
// Character accumulator: sign, digit and overflow handling per text beat.
module dtti_accum (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  dtti_pkg::item_t item,
  output logic          item_stall,
  output logic          snap_valid,
  output dtti_pkg::snap_t snap,
  input  logic          snap_stall
);
  import dtti_pkg::*;

  logic [63:0] magnitude_acc, magnitude_acc_next;
  logic        is_negative, is_negative_next;
  logic        at_first_char, at_first_char_next;
  logic        digit_seen, digit_seen_next;
  status_t     error_code, error_code_next;

  logic [3:0]  digit;
  logic        is_digit;
  logic        is_sign;
  logic [63:0] ovf_lim;
  logic [63:0] times_ten_plus;
  logic        consume;

  // a last beat needs a free snapshot slot; other beats always go through
  assign item_stall = item_valid && item.last_char && snap_valid && snap_stall;
  assign consume    = item_valid && !item_stall;

  assign digit    = item.char_code[3:0];
  assign is_digit = item.char_code inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_sign  = at_first_char &&
                    (item.char_code == CHAR_PLUS || item.char_code == CHAR_MINUS);
  assign ovf_lim  = (digit <= 4'd5) ? OVF_LIM_LOW_DIGIT : OVF_LIM_HIGH_DIGIT;
  // x*10 + d as shifts and adds
  assign times_ten_plus = {magnitude_acc[60:0], 3'b000} + {magnitude_acc[62:0], 1'b0}
                          + {60'd0, digit};

  always_comb begin
    magnitude_acc_next = magnitude_acc;
    is_negative_next   = is_negative;
    at_first_char_next = at_first_char;
    digit_seen_next    = digit_seen;
    error_code_next    = error_code;
    if (item.char_present && error_code == ST_OK) begin
      at_first_char_next = 1'b0;
      if (is_sign) begin
        is_negative_next = (item.char_code == CHAR_MINUS);
      end else if (!is_digit) begin
        error_code_next = ST_MALFORMED;
      end else if (magnitude_acc > ovf_lim) begin
        error_code_next = ST_OVER64;
      end else begin
        magnitude_acc_next = times_ten_plus;
        digit_seen_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_acc <= '0;
      is_negative   <= 1'b0;
      at_first_char <= 1'b1;
      digit_seen    <= 1'b0;
      error_code    <= ST_OK;
    end else if (consume) begin
      if (item.last_char) begin
        magnitude_acc <= '0;
        is_negative   <= 1'b0;
        at_first_char <= 1'b1;
        digit_seen    <= 1'b0;
        error_code    <= ST_OK;
      end else begin
        magnitude_acc <= magnitude_acc_next;
        is_negative   <= is_negative_next;
        at_first_char <= at_first_char_next;
        digit_seen    <= digit_seen_next;
        error_code    <= error_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (consume && item.last_char) begin
      snap_valid <= 1'b1;
    end else if (!snap_stall) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && item.last_char) begin
      snap.magnitude       <= magnitude_acc_next;
      snap.is_negative     <= is_negative_next;
      snap.digit_seen      <= digit_seen_next;
      snap.error_code      <= error_code_next;
      snap.width_code      <= item.width_code;
      snap.is_signed_field <= item.is_signed_field;
    end
  end

endmodule

// ===== sv/dtti_finish.sv =====
// Result stage: range check, two's complement and field truncation.
module dtti_finish (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  input  dtti_pkg::snap_t snap,
  output logic            snap_stall,
  output logic            out_valid,
  output logic [63:0]     field_value,
  output dtti_pkg::status_t status,
  input  logic            out_stall
);
  import dtti_pkg::*;

  logic [6:0]  field_bits;
  logic        full_width;
  logic [63:0] signed_lim;
  logic [63:0] unsigned_lim;
  logic        fits;
  status_t     status_next;
  logic [63:0] twos;
  logic [63:0] value_next;
  logic        take;

  assign snap_stall = out_valid && out_stall;
  assign take       = snap_valid && !snap_stall;

  assign field_bits   = 7'd8 << snap.width_code;
  assign full_width   = (snap.width_code == WCODE_8BYTE);
  assign signed_lim   = 64'd1 << (field_bits - 7'd1);
  // not used for the full 8 byte field
  assign unsigned_lim = 64'd1 << field_bits[5:0];

  always_comb begin
    if (snap.is_signed_field) begin
      fits = snap.is_negative ? (snap.magnitude <= signed_lim)
                              : (snap.magnitude < signed_lim);
    end else if (snap.is_negative) begin
      fits = (snap.magnitude == 64'd0);
    end else begin
      fits = full_width || (snap.magnitude < unsigned_lim);
    end
  end

  always_comb begin
    if (snap.error_code != ST_OK) begin
      status_next = snap.error_code;
    end else if (!snap.digit_seen) begin
      status_next = ST_MALFORMED;
    end else if (!fits) begin
      status_next = ST_RANGE;
    end else begin
      status_next = ST_OK;
    end
  end

  assign twos = snap.is_negative ? (~snap.magnitude + 64'd1) : snap.magnitude;

  always_comb begin
    if (status_next != ST_OK) begin
      value_next = '0;
    end else if (full_width) begin
      value_next = twos;
    end else begin
      value_next = twos & (unsigned_lim - 64'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      field_value <= value_next;
      status      <= status_next;
    end
  end

endmodule

// ===== sv/decimal_text_to_integer.sv =====
// Top level of the ASCII decimal text to binary integer converter.
//
// Usage: text arrives one character per beat on the input channel
// (in_valid / in_stall) with char_code, char_present and last_char. An
// optional leading '+' or '-' is followed by decimal digits. width_code and
// is_signed_field are taken from the beat that carries last_char.
// Only a last beat produces a result beat on the output channel
// (out_valid / out_stall): field_value holds the two's complement value cut
// to 1, 2, 4 or 8 bytes with upper bits zero, status is 0 ok, 1 malformed,
// 2 past 64 bits, 3 out of field range. field_value is zero on any error.
// A last beat passes through the input register, the accumulator snapshot
// and the result register before its result beat is shown.
// Throughput: one beat per cycle while no stall holds the flow; the
// multiply-by-ten is shifts and adds inside the accumulator stage, so
// nothing iterates.
// Reset (rst, synchronous) empties every stage and clears the accumulator.
// When the receiver stalls, the result register holds its beat; a stalled
// snapshot then blocks only the next last beat, while other characters keep
// flowing until every register ahead of the input is full.
module decimal_text_to_integer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        char_present,
  input  logic        last_char,
  input  logic [1:0]  width_code,
  input  logic        is_signed_field,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] field_value,
  output logic [1:0]  status
);
  import dtti_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_stall;
  logic    snap_valid;
  snap_t   snap;
  logic    snap_stall;
  status_t status_q;

  // input register: free when empty or draining this cycle
  assign in_stall = item_valid && item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (!item_stall) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.char_code       <= char_code;
      item.char_present    <= char_present;
      item.last_char       <= last_char;
      item.width_code      <= width_code;
      item.is_signed_field <= is_signed_field;
    end
  end

  dtti_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_stall (snap_stall)
  );

  dtti_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap        (snap),
    .snap_stall  (snap_stall),
    .out_valid   (out_valid),
    .field_value (field_value),
    .status      (status_q),
    .out_stall   (out_stall)
  );

  assign status = status_q;

endmodule

// ===== sv/dtti_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module dtti_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] field_value,
  input logic [1:0]  status
);
  import dtti_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(field_value) && $stable(status))
    else $error("stalled result beat changed");

  // every error reports a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> field_value == 64'd0)
    else $error("nonzero value on error status");

endmodule

bind decimal_text_to_integer dtti_checker u_dtti_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .field_value (field_value),
  .status      (status)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the decimal text to integer converter.
module tb_top;
  import dtti_pkg::*;

  localparam int RANDOM_BEATS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  // Slack run after the last result is back, before the verdict.
  localparam int SETTLE_CYCLES = 10;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_mode_t;

  // One converted number as the block should report it.
  typedef struct {
    logic [63:0] value;
    status_t     status;
  } conversion_t;

  // Tracks the text being parsed and the conversions still owed by the block.
  class conversion_scoreboard;
    logic [63:0]  magnitude;
    bit           negative;
    bit           at_start;
    bit           has_digit;
    status_t      first_error;
    conversion_t  results_due[$];
    int           errors;

    function new();
      errors = 0;
      restart_text();
    endfunction

    function void restart_text();
      magnitude   = '0;
      negative    = 1'b0;
      at_start    = 1'b1;
      has_digit   = 1'b0;
      first_error = ST_OK;
    endfunction

    function bit fits_field(int unsigned nbits, bit sgn);
      logic [63:0] half;
      half = 64'd1 << (nbits - 1);
      if (sgn) return negative ? (magnitude <= half) : (magnitude < half);
      if (negative) return magnitude == 64'd0;
      return nbits == 64 || magnitude < (64'd1 << nbits);
    endfunction

    function void absorb_char(logic [7:0] c);
      logic [63:0] d;
      if (first_error != ST_OK) return;
      if (at_start && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
        negative = (c == CHAR_MINUS);
        at_start = 1'b0;
        return;
      end
      at_start = 1'b0;
      if (c < CHAR_ZERO || c > CHAR_NINE) begin
        first_error = ST_MALFORMED;
        return;
      end
      d = 64'(c - CHAR_ZERO);
      if (magnitude > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
        first_error = ST_OVER64;
        return;
      end
      magnitude = magnitude * 64'd10 + d;
      has_digit = 1'b1;
    endfunction

    // Called for every accepted input beat.
    function void note_beat(item_t b);
      conversion_t r;
      int unsigned nbits;
      if (b.char_present) absorb_char(b.char_code);
      if (!b.last_char) return;
      nbits = 8 << b.width_code;
      r.value  = '0;
      r.status = first_error;
      if (r.status == ST_OK && !has_digit) r.status = ST_MALFORMED;
      if (r.status == ST_OK && !fits_field(nbits, b.is_signed_field)) r.status = ST_RANGE;
      if (r.status == ST_OK) begin
        r.value = negative ? -magnitude : magnitude;
        if (nbits < 64) r.value &= (64'd1 << nbits) - 64'd1;
      end
      results_due.push_back(r);
      restart_text();
    endfunction

    // Called for every accepted result beat.
    function void check_result(logic [63:0] value, logic [1:0] st);
      conversion_t r;
      if (results_due.size() == 0) begin
        $error("result beat with nothing outstanding: field_value %h status %0d", value, st);
        errors++;
        return;
      end
      r = results_due.pop_front();
      if (value !== r.value) begin
        $error("field_value: expected %h, got %h", r.value, value);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        char_present = 1'b0;
  logic        last_char = 1'b0;
  logic [1:0]  width_code = '0;
  logic        is_signed_field = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] field_value;
  logic [1:0]  status;

  conversion_scoreboard sb = new();

  decimal_text_to_integer dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_code       (char_code),
    .char_present    (char_present),
    .last_char       (last_char),
    .width_code      (width_code),
    .is_signed_field (is_signed_field),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .field_value     (field_value),
    .status          (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop so a hung handshake cannot run forever.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall pattern: stretches of no stall, light and heavy random
  // stall, and short solid stalls. Mode and length are redrawn per stretch.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 16)
                                               : $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 2) != 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  // Result monitor: values read here are the ones seen at the edge.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) sb.check_result(field_value, status);
  end

  // ---------------------------------------------------------------------------
  // Text building: a text is a queue of beats, sent as a unit.
  // ---------------------------------------------------------------------------
  item_t text_beats[$];

  // Beat carrying no character; its char_code must be ignored by the block.
  function void add_gap_beat();
    item_t b;
    b.char_code       = 8'($urandom);
    b.char_present    = 1'b0;
    b.last_char       = 1'b0;
    b.width_code      = 2'($urandom_range(0, 3));
    b.is_signed_field = 1'($urandom_range(0, 1));
    text_beats.push_back(b);
  endfunction

  // Width and sign on non-last beats are don't-care, so randomize them.
  function void add_char(logic [7:0] c);
    item_t b;
    b.char_code       = c;
    b.char_present    = 1'b1;
    b.last_char       = 1'b0;
    b.width_code      = 2'($urandom_range(0, 3));
    b.is_signed_field = 1'($urandom_range(0, 1));
    text_beats.push_back(b);
    if ($urandom_range(0, 19) == 0) add_gap_beat();
  endfunction

  function void add_string(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function void add_decimal(logic [63:0] v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CHAR_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 64'd0);
    foreach (digits[i]) add_char(digits[i]);
  endfunction

  function void add_random_sign();
    case ($urandom_range(0, 2))
      0: ;
      1: add_char(CHAR_PLUS);
      default: add_char(CHAR_MINUS);
    endcase
  endfunction

  function logic [7:0] random_non_digit();
    logic [7:0] c;
    do c = 8'($urandom); while (c >= CHAR_ZERO && c <= CHAR_NINE);
    return c;
  endfunction

  // Mark the end of the text: either the last character beat, or a
  // trailing beat with no character (always so for an empty text).
  function void close_text(logic [1:0] wcode, bit sgn);
    item_t b;
    if (text_beats.size() == 0 || $urandom_range(0, 5) == 0) begin
      add_gap_beat();
    end
    b = text_beats.pop_back();
    b.last_char       = 1'b1;
    b.width_code      = wcode;
    b.is_signed_field = sgn;
    text_beats.push_back(b);
  endfunction

  function void build_random_text();
    int unsigned kind;
    int unsigned nbits;
    logic [1:0]  wcode;
    bit          sgn;
    bit          neg;
    logic [63:0] lim;
    logic [63:0] mag;
    wcode = 2'($urandom_range(0, 3));
    sgn   = 1'($urandom_range(0, 1));
    nbits = 8 << wcode;
    kind  = $urandom_range(0, 99);
    if (kind < 35) begin
      // Just inside / just outside the field's range.
      neg = sgn ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 4) == 0);
      if (sgn) lim = 64'd1 << (nbits - 1);
      else if (nbits == 64) lim = '1;
      else lim = 64'd1 << nbits;
      mag = lim + 64'($urandom_range(0, 5)) - 64'd3;
      if (neg) add_char(CHAR_MINUS);
      else if ($urandom_range(0, 3) == 0) add_char(CHAR_PLUS);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) add_char(CHAR_ZERO);
      add_decimal(mag);
    end else if (kind < 65) begin
      // Arbitrary magnitude, mostly small so that results tend to fit.
      add_random_sign();
      if ($urandom_range(0, 4) == 0) add_char(CHAR_ZERO);
      add_decimal({$urandom, $urandom} >> $urandom_range(0, 64));
    end else if (kind < 75) begin
      // Past 2^64 - 1, possibly with junk after the overflow.
      add_random_sign();
      if ($urandom_range(0, 1) == 0) begin
        add_string("1844674407370955161");
        add_char(CHAR_ZERO + 8'($urandom_range(6, 9)));
      end else begin
        add_char(CHAR_ZERO + 8'($urandom_range(2, 9)));
        repeat ($urandom_range(19, 21)) add_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 2) == 0) add_char(random_non_digit());
    end else if (kind < 90) begin
      // Broken sequences.
      case ($urandom_range(0, 3))
        0: add_char($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        1: begin
          add_random_sign();
          add_decimal(64'($urandom_range(0, 99999)));
          add_char(random_non_digit());
          add_decimal(64'($urandom_range(0, 999)));
        end
        2: begin
          add_char($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
          add_char($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
          add_decimal(64'($urandom_range(0, 999)));
        end
        default: ;
      endcase
    end else begin
      // Raw noise over the full byte range.
      repeat ($urandom_range(1, 4)) add_char(8'($urandom));
    end
    close_text(wcode, sgn);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_max    = 4;
  int beats_sent = 0;

  // Entered right after clk rises; returns right after the rise of clk at which the beat is taken.
  task automatic drive_beat(item_t b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid        <= 1'b1;
    char_code       <= b.char_code;
    char_present    <= b.char_present;
    last_char       <= b.last_char;
    width_code      <= b.width_code;
    is_signed_field <= b.is_signed_field;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
    beats_sent++;
    burst_left--;
  endtask

  task automatic send_text();
    while (text_beats.size() != 0) drive_beat(text_beats.pop_front());
  endtask

  task automatic directed_text(string s, logic [1:0] wcode, bit sgn);
    add_string(s);
    close_text(wcode, sgn);
    send_text();
  endtask

  initial begin
    int  random_start;
    bit  drained;
    drained = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field range edges, negative zero, 64-bit limits, malformed
    // forms, charless beats, first error wins.
    directed_text("0", 2'd0, 1'b0);
    directed_text("-0", 2'd0, 1'b0);
    directed_text("255", 2'd0, 1'b0);
    directed_text("256", 2'd0, 1'b0);
    directed_text("-128", 2'd0, 1'b1);
    directed_text("+127", 2'd0, 1'b1);
    directed_text("128", 2'd0, 1'b1);
    directed_text("-129", 2'd0, 1'b1);
    directed_text("-1", 2'd1, 1'b1);
    directed_text("65535", 2'd1, 1'b0);
    directed_text("-5", 2'd2, 1'b0);
    directed_text("2147483648", 2'd2, 1'b1);
    directed_text("18446744073709551615", WCODE_8BYTE, 1'b0);
    directed_text("18446744073709551616", WCODE_8BYTE, 1'b0);
    directed_text("-9223372036854775808", WCODE_8BYTE, 1'b1);
    directed_text("9223372036854775808", WCODE_8BYTE, 1'b1);
    directed_text("+", 2'd0, 1'b0);
    directed_text("-", WCODE_8BYTE, 1'b1);
    directed_text("", 2'd2, 1'b1);
    directed_text("1-2", 2'd1, 1'b0);
    directed_text("+-3", 2'd1, 1'b1);
    directed_text("x99999999999999999999", WCODE_8BYTE, 1'b0);
    directed_text("99999999999999999999z", WCODE_8BYTE, 1'b0);
    // Charless beat inside the text is skipped: "7", gap, "3" is 73.
    add_char(CHAR_ZERO + 8'd7);
    add_gap_beat();
    add_char(CHAR_ZERO + 8'd3);
    close_text(2'd0, 1'b1);
    send_text();
    // Extreme byte values as the only character.
    add_char(8'h00);
    close_text(2'd0, 1'b0);
    add_char(8'hFF);
    close_text(2'd3, 1'b1);
    send_text();

    // Random part. The sender's gap range changes now and then, including
    // stretches with no gaps at all.
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: gap_max = 0;
          1: gap_max = 2;
          default: gap_max = 6;
        endcase
      end
      build_random_text();
      send_text();
      // Once, midway: stop sending until every result is back.
      if (!drained && beats_sent - random_start > RANDOM_BEATS / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        burst_left = 0;
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dtti_pkg.sv
sv/dtti_accum.sv
sv/dtti_finish.sv
sv/decimal_text_to_integer.sv
sv/dtti_checker.sv
tb/sv/tb_top.sv
